/* rtl/core/pidci_pkg.sv */
// ----------------------------------------------------------------------------
// pidci_pkg: shared definitions for the clamped-integral pid core
// widths, command and register codes, saturation helpers
// ----------------------------------------------------------------------------
package pidci_pkg;

  // field widths
  localparam int SAMPLE_WIDTH   = 16;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_W         = 32;
  localparam int DATA_W         = 32;
  localparam int ELAPSED_W      = 16;
  localparam int LIMIT_W        = 16;
  localparam int CMD_W          = 2;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 32;

  // derived datapath widths
  localparam int ERR_W  = SAMPLE_WIDTH + 1;
  localparam int DERR_W = SAMPLE_WIDTH + 2;
  localparam int MAG_W  = (ERR_W > LIMIT_W) ? ERR_W : LIMIT_W;
  localparam int INC_W  = (ERR_W > LIMIT_W + 1) ? ERR_W : LIMIT_W + 1;
  localparam int MUL_W  = (SAMPLE_WIDTH + 1 > GAIN_W) ? SAMPLE_WIDTH + 1 : GAIN_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 64;

  // product magnitudes saturate at 2^60
  localparam int SAT_W  = 61;
  localparam logic [SAT_W-1:0] PROD_LIMIT = {1'b1, {(SAT_W-1){1'b0}}};

  // split of the integral term for the multiply by elapsed time
  localparam int T_LO_W = 32;
  localparam int T_HI_W = SAT_W - T_LO_W;
  localparam int LO_W   = T_LO_W + ELAPSED_W;

  // derivative dividend and divider step counter
  localparam int DQ_W      = (SAMPLE_WIDTH + GAIN_W < SAT_W) ? SAMPLE_WIDTH + GAIN_W : SAT_W;
  localparam int DIV_CNT_W = $clog2(DQ_W);

  localparam logic signed [ACC_W-1:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] S32_MIN = -64'sd2147483648;

  typedef enum logic [CMD_W-1:0] {
    CMD_EVAL  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_LOAD  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TARGET     = 3'd0,
    REG_GAIN_P     = 3'd1,
    REG_GAIN_I     = 3'd2,
    REG_GAIN_D     = 3'd3,
    REG_MIN_SAMPLE = 3'd4,
    REG_STEP_LIMIT = 3'd5,
    REG_TIME_ADJ   = 3'd6
  } cfg_reg_t;

  // magnitude of a signed gain-width word, 2^31 fits unsigned
  function automatic logic [GAIN_W-1:0] mag_gain(input logic [GAIN_W-1:0] a);
    logic [GAIN_W-1:0] r;
    r = a[GAIN_W-1] ? (~a + 1'b1) : a;
    return r;
  endfunction

  // clamp a product magnitude at 2^60
  function automatic logic [SAT_W-1:0] sat_prod(input logic [PROD_W-1:0] p);
    logic [SAT_W-1:0] r;
    if (p > PROD_W'(PROD_LIMIT)) begin
      r = PROD_LIMIT;
    end else begin
      r = p[SAT_W-1:0];
    end
    return r;
  endfunction

  // signed saturation to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/pid_controller_clamped_integral_core.sv */
// ----------------------------------------------------------------------------
// pid_controller_clamped_integral_core: sequenced fixed-point pid step
// one shared multiplier and one 64-bit accumulate adder, driven by a
// one-hot sequencer; derivative time scaling uses a radix-2 divider
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  in      | into core | in_valid/in_stall  | command measurement elapsed_ms integral_load
//  out     | from core | out_valid/out_stall| drive integral_now updated
//  cfg     | into core | cfg_we             | cfg_index cfg_data
//
//  one request at a time: accept, compute, present the result, back to idle
//  evaluate with update: the full sequence, including the divider's DQ_W bit steps
//  when scaling is off or elapsed is one the divider is skipped
//  hold, clear, load: straight from the error state to the result
//  in_stall stays high from acceptance until the result is taken
//  rst is synchronous: configuration registers and pid state go to zero
//
module pid_controller_clamped_integral_core (
  input  logic                                       clk,
  input  logic                                       rst,
  // configuration write port
  input  logic                                       cfg_we,
  input  logic [pidci_pkg::CFG_INDEX_W-1:0]          cfg_index,
  input  logic [pidci_pkg::CFG_DATA_W-1:0]           cfg_data,
  // request channel
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic [pidci_pkg::CMD_W-1:0]                command,
  input  logic signed [pidci_pkg::SAMPLE_WIDTH-1:0]  measurement,
  input  logic [pidci_pkg::ELAPSED_W-1:0]            elapsed_ms,
  input  logic signed [pidci_pkg::DATA_W-1:0]        integral_load,
  // result channel
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic signed [pidci_pkg::DATA_W-1:0]        drive,
  output logic signed [pidci_pkg::DATA_W-1:0]        integral_now,
  output logic                                       updated
);

  // sequencer states, one hot
  typedef enum logic [13:0] {
    S_IDLE   = 14'h0001,
    S_ERR    = 14'h0002,
    S_INT    = 14'h0004,
    S_MUL_P  = 14'h0008,
    S_SAT_P  = 14'h0010,
    S_ADD_P  = 14'h0020,
    S_MUL_IL = 14'h0040,
    S_MUL_IH = 14'h0080,
    S_SAT_I  = 14'h0100,
    S_ADD_I  = 14'h0200,
    S_DIV    = 14'h0400,
    S_ADD_D  = 14'h0800,
    S_FIN    = 14'h1000,
    S_OUT    = 14'h2000
  } state_t;

  state_t state;

  // configuration registers
  logic signed [pidci_pkg::SAMPLE_WIDTH-1:0] target_value;
  logic signed [pidci_pkg::GAIN_W-1:0]       gain_p;
  logic signed [pidci_pkg::GAIN_W-1:0]       gain_i;
  logic signed [pidci_pkg::GAIN_W-1:0]       gain_d;
  logic [pidci_pkg::ELAPSED_W-1:0]           min_sample_ms;
  logic [pidci_pkg::LIMIT_W-1:0]             integral_step_limit;
  logic                                      time_adjust_enable;

  // pid state
  logic signed [pidci_pkg::DATA_W-1:0] integral_sum;
  logic signed [pidci_pkg::ERR_W-1:0]  last_error;
  logic signed [pidci_pkg::DATA_W-1:0] last_drive;
  logic                                upd;

  // captured request
  logic [pidci_pkg::CMD_W-1:0]               cmd_q;
  logic signed [pidci_pkg::SAMPLE_WIDTH-1:0] meas_q;
  logic [pidci_pkg::ELAPSED_W-1:0]           elapsed_q;
  logic signed [pidci_pkg::DATA_W-1:0]       load_q;

  // working registers
  logic signed [pidci_pkg::ERR_W-1:0]  err;
  logic [pidci_pkg::ERR_W-1:0]         err_mag;
  logic signed [pidci_pkg::INC_W-1:0]  inc;
  logic signed [pidci_pkg::DERR_W-1:0] derr;
  logic [pidci_pkg::ELAPSED_W-1:0]     f_val;
  logic [pidci_pkg::PROD_W-1:0]        prod;
  logic [pidci_pkg::SAT_W-1:0]         t_mag;
  logic [pidci_pkg::LO_W-1:0]          lo_part;
  logic [pidci_pkg::DQ_W-1:0]          d_mag;
  logic [pidci_pkg::SAT_W-1:0]         term;
  logic                                term_neg;
  logic signed [pidci_pkg::ACC_W-1:0]  acc;
  logic [pidci_pkg::DQ_W-1:0]          quo;
  logic [pidci_pkg::ELAPSED_W-1:0]     rem;
  logic [pidci_pkg::DIV_CNT_W-1:0]     div_cnt;

  // combinational
  logic                                req_accept;
  logic                                do_update;
  logic signed [pidci_pkg::ERR_W-1:0]  err_calc;
  logic [pidci_pkg::ERR_W-1:0]         err_abs;
  logic                                clamp_hit;
  logic signed [pidci_pkg::INC_W-1:0]  lim_s;
  logic signed [pidci_pkg::INC_W-1:0]  inc_calc;
  logic signed [pidci_pkg::ACC_W-1:0]  isum_wide;
  logic signed [pidci_pkg::DERR_W-1:0] derr_calc;
  logic [pidci_pkg::DERR_W-1:0]        derr_abs;
  logic [pidci_pkg::MUL_W-1:0]         mul_a;
  logic [pidci_pkg::MUL_W-1:0]         mul_b;
  logic [pidci_pkg::SAT_W-1:0]         prod_sat;
  logic                                hi_over;
  logic [pidci_pkg::SAT_W:0]           i_sum;
  logic [pidci_pkg::SAT_W-1:0]         i_mag;
  logic [pidci_pkg::ACC_W-1:0]         addend;
  logic [pidci_pkg::ACC_W-1:0]         acc_sum;
  logic [pidci_pkg::ELAPSED_W:0]       div_r2;
  logic [pidci_pkg::ELAPSED_W:0]       div_diff;
  logic                                div_ge;
  logic signed [pidci_pkg::ACC_W-1:0]  acc_sh;

  // handshake
  assign in_stall     = (state != S_IDLE);
  assign out_valid    = (state == S_OUT);
  assign req_accept   = in_valid && (state == S_IDLE);
  assign drive        = last_drive;
  assign integral_now = integral_sum;
  assign updated      = upd;

  // update only when elapsed time strictly exceeds the minimum
  assign do_update = (elapsed_q > min_sample_ms);

  // error and per-step integral clamp
  always_comb begin
    err_calc  = {target_value[pidci_pkg::SAMPLE_WIDTH-1], target_value}
              - {meas_q[pidci_pkg::SAMPLE_WIDTH-1], meas_q};
    err_abs   = err_calc[pidci_pkg::ERR_W-1] ? (~err_calc + 1'b1) : err_calc;
    clamp_hit = (integral_step_limit != '0)
             && (pidci_pkg::MAG_W'(err_abs) > pidci_pkg::MAG_W'(integral_step_limit));
    lim_s     = pidci_pkg::INC_W'($signed({1'b0, integral_step_limit}));
    if (clamp_hit) begin
      inc_calc = err_calc[pidci_pkg::ERR_W-1] ? -lim_s : lim_s;
    end else begin
      inc_calc = pidci_pkg::INC_W'(err_calc);
    end
  end

  // integral accumulate and error difference
  assign isum_wide = pidci_pkg::ACC_W'(integral_sum) + pidci_pkg::ACC_W'(inc);
  assign derr_calc = pidci_pkg::DERR_W'(err) - pidci_pkg::DERR_W'(last_error);
  assign derr_abs  = derr[pidci_pkg::DERR_W-1] ? (~derr + 1'b1) : derr;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_P: begin
        mul_a = pidci_pkg::MUL_W'(pidci_pkg::mag_gain(gain_p));
        mul_b = pidci_pkg::MUL_W'(err_mag);
      end
      S_SAT_P: begin
        mul_a = pidci_pkg::MUL_W'(pidci_pkg::mag_gain(gain_i));
        mul_b = pidci_pkg::MUL_W'(pidci_pkg::mag_gain(integral_sum));
      end
      S_ADD_P: begin
        mul_a = pidci_pkg::MUL_W'(pidci_pkg::mag_gain(gain_d));
        mul_b = pidci_pkg::MUL_W'(derr_abs[pidci_pkg::DERR_W-2:0]);
      end
      S_MUL_IL: begin
        mul_a = pidci_pkg::MUL_W'(t_mag[pidci_pkg::T_LO_W-1:0]);
        mul_b = pidci_pkg::MUL_W'(f_val);
      end
      S_MUL_IH: begin
        mul_a = pidci_pkg::MUL_W'(t_mag[pidci_pkg::SAT_W-1:pidci_pkg::T_LO_W]);
        mul_b = pidci_pkg::MUL_W'(f_val);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_sat = pidci_pkg::sat_prod(prod);

  // integral term times elapsed: high and low partial products recombined
  always_comb begin
    hi_over = |prod[pidci_pkg::PROD_W-1:pidci_pkg::T_HI_W];
    i_sum   = {1'b0, prod[pidci_pkg::T_HI_W-1:0], {pidci_pkg::T_LO_W{1'b0}}}
            + (pidci_pkg::SAT_W+1)'(lo_part);
    if (hi_over || (i_sum > (pidci_pkg::SAT_W+1)'(pidci_pkg::PROD_LIMIT))) begin
      i_mag = pidci_pkg::PROD_LIMIT;
    end else begin
      i_mag = i_sum[pidci_pkg::SAT_W-1:0];
    end
  end

  // shared accumulate adder, subtracts through the inverted addend
  assign addend  = term_neg ? ~pidci_pkg::ACC_W'(term) : pidci_pkg::ACC_W'(term);
  assign acc_sum = acc + addend + pidci_pkg::ACC_W'(term_neg);

  // restoring divider step
  assign div_r2   = {rem, quo[pidci_pkg::DQ_W-1]};
  assign div_diff = div_r2 - {1'b0, f_val};
  assign div_ge   = (div_r2 >= {1'b0, f_val});

  // floor shift out of the gain fraction
  assign acc_sh = acc >>> pidci_pkg::GAIN_FRAC_BITS;

  // control, configuration and pid state
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      target_value        <= '0;
      gain_p              <= '0;
      gain_i              <= '0;
      gain_d              <= '0;
      min_sample_ms       <= '0;
      integral_step_limit <= '0;
      time_adjust_enable  <= 1'b0;
      integral_sum        <= '0;
      last_error          <= '0;
      last_drive          <= '0;
      upd                 <= 1'b0;
      div_cnt             <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pidci_pkg::REG_TARGET:     target_value <= cfg_data[pidci_pkg::SAMPLE_WIDTH-1:0];
          pidci_pkg::REG_GAIN_P:     gain_p <= cfg_data[pidci_pkg::GAIN_W-1:0];
          pidci_pkg::REG_GAIN_I:     gain_i <= cfg_data[pidci_pkg::GAIN_W-1:0];
          pidci_pkg::REG_GAIN_D:     gain_d <= cfg_data[pidci_pkg::GAIN_W-1:0];
          pidci_pkg::REG_MIN_SAMPLE: min_sample_ms <= cfg_data[pidci_pkg::ELAPSED_W-1:0];
          pidci_pkg::REG_STEP_LIMIT: integral_step_limit <= cfg_data[pidci_pkg::LIMIT_W-1:0];
          pidci_pkg::REG_TIME_ADJ:   time_adjust_enable <= cfg_data[0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (req_accept) begin
            state <= S_ERR;
          end
        end
        S_ERR: begin
          upd <= 1'b0;
          case (cmd_q)
            pidci_pkg::CMD_CLEAR: begin
              integral_sum <= '0;
              last_error   <= '0;
              state        <= S_OUT;
            end
            pidci_pkg::CMD_LOAD: begin
              integral_sum <= load_q;
              state        <= S_OUT;
            end
            pidci_pkg::CMD_EVAL: begin
              state <= do_update ? S_INT : S_OUT;
            end
            default: begin
              // unused command code: hold the pid state, no update flagged
              state <= S_OUT;
            end
          endcase
        end
        S_INT: begin
          integral_sum <= pidci_pkg::sat32(isum_wide);
          last_error   <= err;
          state        <= S_MUL_P;
        end
        S_MUL_P:  state <= S_SAT_P;
        S_SAT_P:  state <= S_ADD_P;
        S_ADD_P:  state <= S_MUL_IL;
        S_MUL_IL: state <= S_MUL_IH;
        S_MUL_IH: state <= S_SAT_I;
        S_SAT_I:  state <= S_ADD_I;
        S_ADD_I: begin
          if (f_val == pidci_pkg::ELAPSED_W'(1)) begin
            state <= S_ADD_D;
          end else begin
            div_cnt <= pidci_pkg::DIV_CNT_W'(pidci_pkg::DQ_W - 1);
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt == '0) begin
            state <= S_ADD_D;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        S_ADD_D:  state <= S_FIN;
        S_FIN: begin
          last_drive <= pidci_pkg::sat32(acc_sh);
          upd        <= 1'b1;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= pidci_pkg::PROD_W'(mul_a) * pidci_pkg::PROD_W'(mul_b);

    case (state)
      S_IDLE: begin
        if (req_accept) begin
          cmd_q     <= command;
          meas_q    <= measurement;
          elapsed_q <= elapsed_ms;
          load_q    <= integral_load;
        end
      end
      S_ERR: begin
        err     <= err_calc;
        err_mag <= err_abs;
        inc     <= inc_calc;
        f_val   <= time_adjust_enable ? elapsed_q : pidci_pkg::ELAPSED_W'(1);
      end
      S_INT: begin
        derr <= derr_calc;
        acc  <= '0;
      end
      S_SAT_P: begin
        // proportional product
        term     <= prod_sat;
        term_neg <= gain_p[pidci_pkg::GAIN_W-1] ^ err[pidci_pkg::ERR_W-1];
      end
      S_ADD_P: begin
        acc   <= acc_sum;
        t_mag <= prod_sat;
      end
      S_MUL_IL: begin
        d_mag <= prod_sat[pidci_pkg::DQ_W-1:0];
      end
      S_MUL_IH: begin
        lo_part <= prod[pidci_pkg::LO_W-1:0];
      end
      S_SAT_I: begin
        term     <= i_mag;
        term_neg <= gain_i[pidci_pkg::GAIN_W-1] ^ integral_sum[pidci_pkg::DATA_W-1];
      end
      S_ADD_I: begin
        acc      <= acc_sum;
        term_neg <= gain_d[pidci_pkg::GAIN_W-1] ^ derr[pidci_pkg::DERR_W-1];
        if (f_val == pidci_pkg::ELAPSED_W'(1)) begin
          term <= pidci_pkg::SAT_W'(d_mag);
        end else begin
          quo <= d_mag;
          rem <= '0;
        end
      end
      S_DIV: begin
        rem <= div_ge ? div_diff[pidci_pkg::ELAPSED_W-1:0] : div_r2[pidci_pkg::ELAPSED_W-1:0];
        quo <= {quo[pidci_pkg::DQ_W-2:0], div_ge};
        if (div_cnt == '0) begin
          term <= pidci_pkg::SAT_W'({quo[pidci_pkg::DQ_W-2:0], div_ge});
        end
      end
      S_ADD_D: begin
        acc <= acc_sum;
      end
      default: ;
    endcase
  end

  // no new request while a result is pending
  a_busy_with_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request accepted while result pending");

  // a taken result frees the core on the next cycle
  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !in_stall)
    else $error("core not idle after result taken");

  // an accepted request leaves the core busy, with no result yet, in the next cycle
  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (in_stall && !out_valid))
    else $error("core not busy after accepting a request");

  // a held evaluate leaves the integral alone and reports no update
  a_hold_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (state == S_ERR && cmd_q == pidci_pkg::CMD_EVAL && !do_update)
      |=> (out_valid && !updated && $stable(integral_sum)))
    else $error("held evaluate changed state");

  // only an evaluate request can flag a new drive
  a_update_only_eval: assert property (@(posedge clk) disable iff (rst)
    (out_valid && updated) |-> (cmd_q == pidci_pkg::CMD_EVAL))
    else $error("update flagged for a non-evaluate request");

endmodule
